### rtl/core/pcsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsr_pkg
// Shared types, codes and constants of the paged section reader.
// ----------------------------------------------------------------------------
package pcsr_pkg;

  localparam int ADDR_BITS_DEF = 48;
  localparam int POS_W         = 48;
  localparam int PAGE_W        = 21;
  localparam int PPOS_W        = 20;
  localparam int HDR_W         = 5;
  localparam int DIV_W         = POS_W + 1;

  localparam logic [PAGE_W-1:0] PAGE_MIN  = 21'd1024;
  localparam logic [PAGE_W-1:0] PAGE_MAX  = 21'd1048576;
  localparam logic [PAGE_W-1:0] CRC_BYTES = 21'd4;

  // request codes
  localparam logic [1:0] REQ_SEEK_ABS = 2'd0;
  localparam logic [1:0] REQ_SEEK_REL = 2'd1;
  localparam logic [1:0] REQ_SEEK_END = 2'd2;
  localparam logic [1:0] REQ_RAW      = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_ADDR = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_CRC  = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  // register indexes
  localparam logic [1:0] CFG_BASE_OFFSET    = 2'd0;
  localparam logic [1:0] CFG_PAGE_SIZE      = 2'd1;
  localparam logic [1:0] CFG_SECTION_LENGTH = 2'd2;
  localparam logic [1:0] CFG_HEADER_SIZE    = 2'd3;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [POS_W-1:0] offset;
    logic [7:0]       raw_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [POS_W-1:0] phys_address;
    logic [7:0]       data_byte;
    logic             at_end;
  } out_item_t;

  typedef struct packed {
    logic raw_step;
    logic seek_load;
    logic mod_start;
    logic div_start;
    logic seek_finish;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

### rtl/core/pcsr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsr_div
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module pcsr_div import pcsr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  dividend_i,
  input  logic [PAGE_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  quot_o,
  output logic [PAGE_W-1:0] rem_o
);

  localparam int CntW = $clog2(DIV_W);

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [DIV_W-1:0]  quot_q;
  logic [PAGE_W-1:0] rem_q;
  logic [PAGE_W-1:0] divisor_q;
  logic [PAGE_W:0]   rem_sh;
  logic [PAGE_W:0]   rem_nx;
  logic              ge;

  assign rem_sh = {rem_q, quot_q[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, divisor_q};
  assign rem_nx = ge ? (rem_sh - {1'b0, divisor_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(DIV_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q    <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[DIV_W-2:0], ge};
      rem_q  <= rem_nx[PAGE_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

### rtl/core/pcsr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsr_datapath
// Configuration, position state, address arithmetic and result register.
// ----------------------------------------------------------------------------
module pcsr_datapath import pcsr_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  output dp_status_t       status_o,
  input  in_item_t         in_data_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [POS_W-1:0] cfg_data_i,
  output out_item_t        out_data_o
);

  localparam int MaskBits = (ADDR_BITS < POS_W) ? ADDR_BITS : POS_W;
  localparam logic [POS_W-1:0] AddrMask =
    (MaskBits >= POS_W) ? {POS_W{1'b1}} : POS_W'((64'd1 << MaskBits) - 64'd1);

  logic [POS_W-1:0]  base_q, sect_len_q;
  logic [PAGE_W-1:0] page_size_q;
  logic [HDR_W-1:0]  header_q;

  logic [POS_W-1:0]  lpos_q;
  logic [PPOS_W-1:0] ppos_q;
  logic              end_q;
  logic [DIV_W-1:0]  lin_q;
  out_item_t         out_q;

  logic [PAGE_W-1:0] p_clamp, p_eff, lp;
  logic [PAGE_W-1:0] pp1;
  logic              at_or_past_end, in_crc;
  logic [POS_W-1:0]  seek_pos;
  logic [DIV_W-1:0]  sum;
  logic [POS_W-1:0]  addr;

  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [PAGE_W-1:0] div_divisor;
  logic              div_done;
  logic [DIV_W-1:0]  div_quot;
  logic [PAGE_W-1:0] div_rem;

  // effective page size: saturate, then drop the two low bits
  always_comb begin
    if (page_size_q < PAGE_MIN) begin
      p_clamp = PAGE_MIN;
    end else if (page_size_q > PAGE_MAX) begin
      p_clamp = PAGE_MAX;
    end else begin
      p_clamp = page_size_q;
    end
    p_eff = {p_clamp[PAGE_W-1:2], 2'b00};
    lp    = p_eff - CRC_BYTES;
  end

  assign pp1            = {1'b0, ppos_q} + PAGE_W'(1);
  assign at_or_past_end = end_q || (lpos_q >= sect_len_q);
  assign in_crc         = {1'b0, ppos_q} >= lp;

  always_comb begin
    case (in_data_i.req_type)
      REQ_SEEK_ABS: seek_pos = in_data_i.offset;
      REQ_SEEK_REL: seek_pos = lpos_q + in_data_i.offset;
      default:      seek_pos = sect_len_q;
    endcase
  end

  assign sum  = {{(DIV_W-PAGE_W){1'b0}}, div_rem} + lin_q;
  assign addr = (base_q + lin_q[POS_W-1:0] + {div_quot[POS_W-3:0], 2'b00}) & AddrMask;

  // pass 1: base mod page; pass 2: (rem+pos+hdr) div (page-4)
  assign div_start    = cmd_i.mod_start || cmd_i.div_start;
  assign div_dividend = cmd_i.mod_start ? {1'b0, base_q} : sum;
  assign div_divisor  = cmd_i.mod_start ? p_eff : lp;

  pcsr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign status_o.div_done = div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      page_size_q <= PAGE_MIN;
      sect_len_q  <= '0;
      header_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BASE_OFFSET:    base_q      <= cfg_data_i;
        CFG_PAGE_SIZE:      page_size_q <= cfg_data_i[PAGE_W-1:0];
        CFG_SECTION_LENGTH: sect_len_q  <= cfg_data_i;
        CFG_HEADER_SIZE:    header_q    <= cfg_data_i[HDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lpos_q <= '0;
      ppos_q <= '0;
      end_q  <= 1'b0;
    end else if (cmd_i.seek_load) begin
      lpos_q <= seek_pos;
      end_q  <= 1'b0;
    end else if (cmd_i.seek_finish) begin
      ppos_q <= div_rem[PPOS_W-1:0];
    end else if (cmd_i.raw_step) begin
      if (at_or_past_end) begin
        end_q <= 1'b1;
      end else if (in_crc) begin
        ppos_q <= (pp1 >= p_eff) ? '0 : pp1[PPOS_W-1:0];
      end else begin
        lpos_q <= lpos_q + POS_W'(1);
        ppos_q <= pp1[PPOS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lin_q <= {1'b0, lpos_q} + {{(DIV_W-HDR_W){1'b0}}, header_q};
    if (cmd_i.seek_finish) begin
      out_q.result_kind  <= KIND_ADDR;
      out_q.phys_address <= addr;
      out_q.data_byte    <= '0;
      out_q.at_end       <= 1'b0;
    end else if (cmd_i.raw_step) begin
      out_q.phys_address <= '0;
      if (at_or_past_end) begin
        out_q.result_kind <= KIND_END;
        out_q.data_byte   <= '0;
        out_q.at_end      <= 1'b1;
      end else if (in_crc) begin
        out_q.result_kind <= KIND_CRC;
        out_q.data_byte   <= '0;
        out_q.at_end      <= 1'b0;
      end else begin
        out_q.result_kind <= KIND_DATA;
        out_q.data_byte   <= in_data_i.raw_byte;
        out_q.at_end      <= 1'b0;
      end
    end
  end

  assign out_data_o = out_q;

endmodule

### rtl/core/pcsr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsr_ctrl
// Sequencer for seeks and handshake control of both channels.
// ----------------------------------------------------------------------------
module pcsr_ctrl import pcsr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_req_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_DIV
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_i == REQ_RAW) begin
            cmd_o.raw_step = 1'b1;
          end else begin
            cmd_o.seek_load = 1'b1;
            cmd_o.mod_start = 1'b1;
            state_d         = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (status_i.div_done) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          cmd_o.seek_finish = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.raw_step || cmd_o.seek_finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/core/paged_crc_section_reader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_crc_section_reader
// Logical-to-physical seek and CRC tail stripping for a paged section.
// ----------------------------------------------------------------------------
// raw byte: result in the cycle after its transfer, one byte per cycle unless
//   the output stalls; seek: the address result comes from the shared
//   bit-serial divider (49 steps for base mod page, 49 for position div page-4)
// no new transfer is taken while a seek is at work
// reset (rst_ni, async, active low): config to reset values, position, page
//   position and end flag to zero, output empty
// ----------------------------------------------------------------------------
module paged_crc_section_reader import pcsr_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input item channel
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o,
  // configuration writes
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [POS_W-1:0] cfg_data_i
);

  // commands from the sequencer, status back from the datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // controller: accepts a transfer only when the result register is free
  // or drains in the same cycle, and runs the two divider passes of a seek
  pcsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_data_i.req_type),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // datapath: config registers, logical and page position, address math
  pcsr_datapath #(
    .ADDR_BITS (ADDR_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/core/pcsr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsr_checker
// Port-level checks of the paged section reader, bound to the top level.
// ----------------------------------------------------------------------------
module pcsr_checker import pcsr_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // a pending result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // single result register: no input transfer while a result is stuck
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> !out_valid_o || out_ready_i)
    else $error("input taken with result register full");

  // a raw byte answers in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.req_type == REQ_RAW) |=> out_valid_o)
    else $error("raw byte result missing");

endmodule

bind paged_crc_section_reader pcsr_checker u_pcsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
